>>> hw/rtl/kalman_filter_position_velocity_defines.svh
// assertion macros shared by the checker
`ifndef KALMAN_FILTER_POSITION_VELOCITY_DEFINES_SVH
`define KALMAN_FILTER_POSITION_VELOCITY_DEFINES_SVH

`define KF_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

`define KF_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

>>> hw/rtl/kfpv_pkg.sv
package kfpv_pkg;

    localparam int unsigned W = 32;

    typedef enum logic [2:0] {
        CFG_QPP = 3'd0,
        CFG_QPV = 3'd1,
        CFG_QVP = 3'd2,
        CFG_QVV = 3'd3,
        CFG_R   = 3'd4,
        CFG_A   = 3'd5
    } t_cfg_idx;

    typedef enum logic [1:0] {
        ST_IDLE = 2'd0,
        ST_RUN  = 2'd1,
        ST_DIV  = 2'd2,
        ST_OUT  = 2'd3
    } t_state;

    // micro-op: multiplier operand selects and destination
    typedef enum logic [4:0] {
        OP_T,     // t = min(t+dt, max)
        OP_AT,    // u = mul(a, t)
        OP_S,     // s = mulh(u, t)
        OP_Z,     // z = sat(s + noise)
        OP_B0,    // b0 = mulh(dt, dt)
        OP_XA,    // acc = x0 + mul(dt, x1)
        OP_XR0,   // xr0 = sat(acc + mul(b0, a))
        OP_XR1,   // xr1 = sat(x1 + mul(dt, a))
        OP_M00,   // m00 = sat(p00 + mul(dt, p10))
        OP_M01,   // m01 = sat(p01 + mul(dt, p11))
        OP_R00,   // r00 = sat(m00 + mul(m01, dt) + qpp)
        OP_R01,   // r01 = sat(m01 + qpv)
        OP_R10,   // r10 = sat(p10 + mul(p11, dt) + qvp)
        OP_R11,   // r11 = sat(p11 + qvv)
        OP_Y,     // y = sat(z - xr0)
        OP_X0,    // x0 = sat(xr0 + mul(k0, y))
        OP_X1,    // x1 = sat(xr1 + mul(k1, y))
        OP_P00,
        OP_P01,
        OP_P10,
        OP_P11
    } t_op;

    localparam int unsigned NUM_PRE = 14; // ops before the divide
    localparam int unsigned NUM_OPS = 21;

    typedef struct packed {
        logic        start;
        logic [63:0] num;
        logic [63:0] den;
    } t_div_req;

    typedef struct packed {
        logic        busy;
        logic        done;
        logic [63:0] quo;
    } t_div_rsp;

    function automatic logic signed [W-1:0] sat32(input logic signed [65:0] v);
        logic signed [65:0] hi;
        logic signed [65:0] lo;
        hi = 66'sd2147483647;
        lo = -66'sd2147483648;
        if (v > hi) return 32'sh7fffffff;
        if (v < lo) return 32'sh80000000;
        return v[W-1:0];
    endfunction

endpackage

>>> hw/rtl/kfpv_if.sv
interface kfpv_in_if (input logic i_clk);
    logic                        valid;
    logic                        ready;
    logic signed [31:0]          noise_sample;
    logic        [30:0]          time_step;
    modport source (output valid, noise_sample, time_step, input ready);
    modport sink (input valid, noise_sample, time_step, output ready);
endinterface

interface kfpv_out_if (input logic i_clk);
    logic               valid;
    logic               ready;
    logic signed [31:0] measured_position;
    logic signed [31:0] true_position;
    logic signed [31:0] filtered_position;
    modport source (output valid, measured_position, true_position, filtered_position,
                    input ready);
    modport sink (input valid, measured_position, true_position, filtered_position,
                  output ready);
endinterface

interface kfpv_cfg_if (input logic i_clk);
    logic        valid;
    logic        ready;
    logic [2:0]  index;
    logic [31:0] data;
    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

>>> hw/rtl/kalman_filter_position_velocity.sv
// two-state position/velocity tracking filter under constant acceleration
// channels: in (noise_sample, time_step), out (measured, true and filtered
// position), cfg (register index 0..5 and 32-bit data, always ready)
// all values are signed Q16.16; time_step and noise variance are unsigned
// one item at a time: the input channel is ready only while no item is at
// work; an item runs 14 multiply/add steps, two gain divisions on a
// bit-serial divider, then 7 more steps before the result beat is offered
// a zero innovation variance skips both divisions
// the result sits in an output register; a stalled receiver holds it and
// the next item is accepted from the cycle after the result is taken
// reset (synchronous, active low) clears estimates, covariance and elapsed
// time, and loads the default noise, variance and acceleration registers
// configuration must be written by the user only while the block is idle;
// the block itself does not enforce this
module kalman_filter_position_velocity (
    input  logic       i_clk,
    input  logic       i_rst_n,
    kfpv_in_if.sink    in_ch,
    kfpv_out_if.source out_ch,
    kfpv_cfg_if.sink   cfg_ch
);
    kfpv_core u_core (
        .i_clk  (i_clk),
        .i_rst_n (i_rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch),
        .cfg_ch (cfg_ch)
    );
endmodule

>>> hw/rtl/kfpv_div.sv
// restoring divider, one quotient bit per cycle, unsigned 64 / 64
module kfpv_div (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  kfpv_pkg::t_div_req  i_req,
    output kfpv_pkg::t_div_rsp  o_rsp
);
    logic [63:0] r_rem;
    logic [63:0] r_quo;
    logic [63:0] r_den;
    logic [6:0]  r_cnt;
    logic        r_busy;
    logic        r_done;
    logic [64:0] n_rem_sh;

    assign n_rem_sh = {r_rem, r_quo[63]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= 7'd64;
            end else if (r_busy) begin
                r_cnt <= r_cnt - 7'd1;
                if (r_cnt == 7'd1) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_rem <= '0;
            r_quo <= i_req.num;
            r_den <= i_req.den;
        end else if (r_busy) begin
            if (n_rem_sh >= {1'b0, r_den}) begin
                r_rem <= 64'(n_rem_sh - {1'b0, r_den});
                r_quo <= {r_quo[62:0], 1'b1};
            end else begin
                r_rem <= n_rem_sh[63:0];
                r_quo <= {r_quo[62:0], 1'b0};
            end
        end
    end

    assign o_rsp.busy = r_busy;
    assign o_rsp.done = r_done;
    assign o_rsp.quo  = r_quo;
endmodule

>>> hw/rtl/kfpv_core.sv
// sequencer around one shared 32x32 multiplier and one adder
module kfpv_core (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    kfpv_in_if.sink                    in_ch,
    kfpv_out_if.source                 out_ch,
    kfpv_cfg_if.sink                   cfg_ch
);
    logic signed [31:0] r_qpp, r_qpv, r_qvp, r_qvv, r_a;
    logic        [30:0] r_rn;
    logic signed [31:0] r_x0, r_x1, r_p00, r_p01, r_p10, r_p11, r_t;
    logic signed [31:0] r_noise, r_dt;
    logic signed [31:0] r_u, r_s, r_z, r_b0, r_xr0, r_xr1, r_m00, r_m01;
    logic signed [31:0] r_r00, r_r01, r_r10, r_r11, r_y, r_k0, r_k1;
    logic signed [65:0] r_acc;
    logic signed [63:0] r_prod;
    logic               r_ph;      // 0: multiply, 1: accumulate
    logic [4:0]         r_op;
    logic               r_dk;      // which gain is in the divider
    logic               r_dstart;
    logic               r_ovalid;
    kfpv_pkg::t_state   r_state, n_state;
    kfpv_pkg::t_div_req w_dreq;
    kfpv_pkg::t_div_rsp w_drsp;

    logic signed [31:0] w_ma, w_mb;
    logic [4:0]         w_sh;
    logic signed [63:0] w_rnd;
    logic signed [65:0] w_sum;
    logic signed [31:0] w_res;
    logic signed [32:0] w_sv;
    logic               w_last;
    logic signed [32:0] w_num;
    logic [63:0]        w_nmag;
    logic [63:0]        w_dmag;
    logic [63:0]        w_q;
    logic signed [32:0] w_qs;
    logic               w_neg;
    kfpv_pkg::t_op      w_op;

    assign w_op = kfpv_pkg::t_op'(r_op);

    // configuration
    assign cfg_ch.ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_qpp <= 32'sd655;
            r_qpv <= '0;
            r_qvp <= '0;
            r_qvv <= 32'sd655;
            r_rn  <= 31'd65536000;
            r_a   <= 32'sd32768;
        end else if (cfg_ch.valid) begin
            unique case (cfg_ch.index)
                kfpv_pkg::CFG_QPP: r_qpp <= cfg_ch.data;
                kfpv_pkg::CFG_QPV: r_qpv <= cfg_ch.data;
                kfpv_pkg::CFG_QVP: r_qvp <= cfg_ch.data;
                kfpv_pkg::CFG_QVV: r_qvv <= cfg_ch.data;
                kfpv_pkg::CFG_R:   r_rn  <= cfg_ch.data[30:0];
                kfpv_pkg::CFG_A:   r_a   <= cfg_ch.data;
                default: ;
            endcase
        end
    end

    // multiplier operands per op
    always_comb begin
        w_ma = '0;
        w_mb = '0;
        w_sh = 5'd16;
        unique case (w_op)
            kfpv_pkg::OP_AT:  begin w_ma = r_a;   w_mb = r_t;  end
            kfpv_pkg::OP_S:   begin w_ma = r_u;   w_mb = r_t;  w_sh = 5'd17; end
            kfpv_pkg::OP_B0:  begin w_ma = r_dt;  w_mb = r_dt; w_sh = 5'd17; end
            kfpv_pkg::OP_XA:  begin w_ma = r_dt;  w_mb = r_x1; end
            kfpv_pkg::OP_XR0: begin w_ma = r_b0;  w_mb = r_a;  end
            kfpv_pkg::OP_XR1: begin w_ma = r_dt;  w_mb = r_a;  end
            kfpv_pkg::OP_M00: begin w_ma = r_dt;  w_mb = r_p10; end
            kfpv_pkg::OP_M01: begin w_ma = r_dt;  w_mb = r_p11; end
            kfpv_pkg::OP_R00: begin w_ma = r_m01; w_mb = r_dt; end
            kfpv_pkg::OP_R10: begin w_ma = r_p11; w_mb = r_dt; end
            kfpv_pkg::OP_X0:  begin w_ma = r_k0;  w_mb = r_y;  end
            kfpv_pkg::OP_X1:  begin w_ma = r_k1;  w_mb = r_y;  end
            kfpv_pkg::OP_P00: begin w_ma = r_k0;  w_mb = r_r00; end
            kfpv_pkg::OP_P01: begin w_ma = r_k0;  w_mb = r_r01; end
            kfpv_pkg::OP_P10: begin w_ma = r_k1;  w_mb = r_r00; end
            kfpv_pkg::OP_P11: begin w_ma = r_k1;  w_mb = r_r01; end
            default: ;
        endcase
    end

    // rounded, saturated product term from the registered product
    always_comb begin
        logic signed [64:0] p;
        p = 65'(r_prod) + (65'sd1 <<< (w_sh - 5'd1));
        w_rnd = 64'(kfpv_pkg::sat32(66'(p >>> w_sh)));
    end

    // adder stage
    always_comb begin
        w_sum = '0;
        unique case (w_op)
            kfpv_pkg::OP_T:   w_sum = 66'(r_t) + 66'(r_dt);
            kfpv_pkg::OP_AT,
            kfpv_pkg::OP_S,
            kfpv_pkg::OP_B0:  w_sum = 66'(w_rnd);
            kfpv_pkg::OP_Z:   w_sum = 66'(r_s) + 66'(r_noise);
            kfpv_pkg::OP_XA:  w_sum = 66'(r_x0) + 66'(w_rnd);
            kfpv_pkg::OP_XR0: w_sum = r_acc + 66'(w_rnd);
            kfpv_pkg::OP_XR1: w_sum = 66'(r_x1) + 66'(w_rnd);
            kfpv_pkg::OP_M00: w_sum = 66'(r_p00) + 66'(w_rnd);
            kfpv_pkg::OP_M01: w_sum = 66'(r_p01) + 66'(w_rnd);
            kfpv_pkg::OP_R00: w_sum = 66'(r_m00) + 66'(w_rnd) + 66'(r_qpp);
            kfpv_pkg::OP_R01: w_sum = 66'(r_m01) + 66'(r_qpv);
            kfpv_pkg::OP_R10: w_sum = 66'(r_p10) + 66'(w_rnd) + 66'(r_qvp);
            kfpv_pkg::OP_R11: w_sum = 66'(r_p11) + 66'(r_qvv);
            kfpv_pkg::OP_Y:   w_sum = 66'(r_z) - 66'(r_xr0);
            kfpv_pkg::OP_X0:  w_sum = 66'(r_xr0) + 66'(w_rnd);
            kfpv_pkg::OP_X1:  w_sum = 66'(r_xr1) + 66'(w_rnd);
            kfpv_pkg::OP_P00: w_sum = 66'(r_r00) - 66'(w_rnd);
            kfpv_pkg::OP_P01: w_sum = 66'(r_r01) - 66'(w_rnd);
            kfpv_pkg::OP_P10: w_sum = 66'(r_r10) - 66'(w_rnd);
            kfpv_pkg::OP_P11: w_sum = 66'(r_r11) - 66'(w_rnd);
            default: ;
        endcase
        w_res = kfpv_pkg::sat32(w_sum);
    end

    // divider operands: (2|n|<<16 + |d|) / (2|d|)
    assign w_sv   = 33'(r_r00) + 33'($signed({1'b0, r_rn}));
    assign w_num  = r_dk ? 33'(r_r10) : 33'(r_r00);
    assign w_nmag = {30'd0, (w_num[32] ? 33'(-w_num) : w_num), 1'b0} << 16;
    assign w_dmag = {31'd0, (w_sv[32] ? 33'(-w_sv) : w_sv)};
    assign w_neg  = w_num[32] != w_sv[32];
    assign w_dreq.start = r_dstart;
    assign w_dreq.num   = w_nmag + w_dmag;
    assign w_dreq.den   = w_dmag << 1;
    // quotient clipped to 2^31 before sign
    assign w_q  = w_drsp.quo;
    always_comb begin
        logic [32:0] m;
        m = (w_q > 64'h8000_0000) ? 33'h0_8000_0000 : w_q[32:0];
        w_qs = w_neg ? 33'(-$signed(m)) : $signed(m);
    end

    kfpv_div u_div (
        .i_clk (i_clk),
        .i_rst_n (i_rst_n),
        .i_req (w_dreq),
        .o_rsp (w_drsp)
    );

    assign w_last = (r_op == 5'(kfpv_pkg::NUM_OPS - 1)) && r_ph;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            kfpv_pkg::ST_IDLE: if (in_ch.valid) n_state = kfpv_pkg::ST_RUN;
            kfpv_pkg::ST_RUN: begin
                if (r_ph && r_op == 5'(kfpv_pkg::NUM_PRE - 1)) n_state = kfpv_pkg::ST_DIV;
                else if (w_last) n_state = kfpv_pkg::ST_OUT;
            end
            kfpv_pkg::ST_DIV: begin
                // leave once the second gain is in
                if (r_ph && r_dk && (w_sv == 33'sd0 || w_drsp.done))
                    n_state = kfpv_pkg::ST_RUN;
            end
            kfpv_pkg::ST_OUT: if (!r_ovalid || out_ch.ready) n_state = kfpv_pkg::ST_IDLE;
            default: n_state = kfpv_pkg::ST_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        in_ch.ready = 1'b0;
        unique case (r_state)
            kfpv_pkg::ST_IDLE: in_ch.ready = !r_ovalid || out_ch.ready;
            default: in_ch.ready = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= kfpv_pkg::ST_IDLE;
            r_ph     <= 1'b0;
            r_op     <= '0;
            r_dk     <= 1'b0;
            r_dstart <= 1'b0;
            r_ovalid <= 1'b0;
            r_x0 <= '0; r_x1 <= '0; r_t <= '0;
            r_p00 <= '0; r_p01 <= '0; r_p10 <= '0; r_p11 <= '0;
        end else begin
            r_state  <= n_state;
            r_dstart <= 1'b0;
            if (r_ovalid && out_ch.ready) r_ovalid <= 1'b0;
            unique case (r_state)
                kfpv_pkg::ST_IDLE: begin
                    if (in_ch.valid && in_ch.ready) begin
                        r_noise <= in_ch.noise_sample;
                        r_dt    <= $signed({1'b0, in_ch.time_step});
                        r_op    <= '0;
                        r_ph    <= 1'b0;
                    end
                end
                kfpv_pkg::ST_RUN: begin
                    r_ph <= !r_ph;
                    if (!r_ph) begin
                        r_prod <= w_ma * w_mb;
                    end else begin
                        r_op <= r_op + 5'd1;
                        unique case (w_op)
                            kfpv_pkg::OP_T:   r_t <= w_res;
                            kfpv_pkg::OP_AT:  r_u <= w_res;
                            kfpv_pkg::OP_S:   r_s <= w_res;
                            kfpv_pkg::OP_Z:   r_z <= w_res;
                            kfpv_pkg::OP_B0:  r_b0 <= w_res;
                            kfpv_pkg::OP_XA:  r_acc <= w_sum;
                            kfpv_pkg::OP_XR0: r_xr0 <= w_res;
                            kfpv_pkg::OP_XR1: r_xr1 <= w_res;
                            kfpv_pkg::OP_M00: r_m00 <= w_res;
                            kfpv_pkg::OP_M01: r_m01 <= w_res;
                            kfpv_pkg::OP_R00: r_r00 <= w_res;
                            kfpv_pkg::OP_R01: r_r01 <= w_res;
                            kfpv_pkg::OP_R10: r_r10 <= w_res;
                            kfpv_pkg::OP_R11: begin
                                r_r11 <= w_res;
                                r_dk  <= 1'b0;
                            end
                            kfpv_pkg::OP_Y:   r_y <= w_res;
                            kfpv_pkg::OP_X0:  r_x0 <= w_res;
                            kfpv_pkg::OP_X1:  r_x1 <= w_res;
                            kfpv_pkg::OP_P00: r_p00 <= w_res;
                            kfpv_pkg::OP_P01: r_p01 <= w_res;
                            kfpv_pkg::OP_P10: r_p10 <= w_res;
                            kfpv_pkg::OP_P11: begin
                                r_p11    <= w_res;
                                r_ovalid <= 1'b1;
                            end
                            default: ;
                        endcase
                    end
                end
                kfpv_pkg::ST_DIV: begin
                    // r_ph 0: launch, 1: wait for done
                    if (!r_ph) begin
                        if (w_sv == 33'sd0) begin
                            r_k0 <= '0;
                            r_k1 <= '0;
                            r_dk <= 1'b1;
                            r_ph <= 1'b1;
                        end else if (!w_drsp.busy && !r_dstart) begin
                            r_dstart <= 1'b1;
                            r_ph     <= 1'b1;
                        end
                    end else if (w_sv == 33'sd0) begin
                        r_ph <= 1'b0;
                    end else if (w_drsp.done) begin
                        if (r_dk) begin
                            r_k1 <= kfpv_pkg::sat32(66'(w_qs));
                            r_ph <= 1'b0;
                        end else begin
                            r_k0 <= kfpv_pkg::sat32(66'(w_qs));
                            r_dk <= 1'b1;
                            r_ph <= 1'b0;
                        end
                    end
                end
                kfpv_pkg::ST_OUT: ;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == kfpv_pkg::ST_RUN && r_ph && w_op == kfpv_pkg::OP_P11) begin
            out_ch.measured_position <= r_z;
            out_ch.true_position     <= r_s;
            out_ch.filtered_position <= r_x0;
        end
    end
    assign out_ch.valid = r_ovalid;
endmodule

>>> hw/rtl/kfpv_checker.sv
`include "kalman_filter_position_velocity_defines.svh"

module kfpv_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic [31:0] out_meas
);
    // output holds while stalled
    `KF_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, out_valid && !out_ready, out_valid && $stable(out_meas))
    // an accepted item blocks further input for the next cycle
    `KF_ASSERT_NXT(a_one_item, i_clk, i_rst_n, in_valid && in_ready, !in_ready)
    // no new result right after an input accept
    `KF_ASSERT_NXT(a_no_early, i_clk, i_rst_n, in_valid && in_ready && !out_valid, !out_valid)
endmodule

bind kalman_filter_position_velocity kfpv_checker u_chk (
    .i_clk     (i_clk),
    .i_rst_n   (i_rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_meas  (out_ch.measured_position)
);

>>> test/kfpv_tb_if.sv
`timescale 1ns / 100ps
// the channel interfaces are shared with the rtl sources

>>> test/kalman_filter_position_velocity_tb.sv
`timescale 1ns / 100ps
module kalman_filter_position_velocity_tb;

    typedef struct packed {
        logic signed [31:0] meas;
        logic signed [31:0] truth;
        logic signed [31:0] filt;
    } t_pos;

    class track_scoreboard;
        longint qpp, qpv, qvp, qvv, rn, acc;
        longint x0, x1, t;
        longint p[4];
        t_pos   pending[$];
        int     mismatches;

        function void clear();
            qpp = 655; qpv = 0; qvp = 0; qvv = 655; rn = 65536000; acc = 32768;
            x0 = 0; x1 = 0; t = 0;
            foreach (p[i]) p[i] = 0;
        endfunction

        function longint sat(longint v);
            if (v > 64'sd2147483647) return 64'sd2147483647;
            if (v < -64'sd2147483648) return -64'sd2147483648;
            return v;
        endfunction

        function longint mulr(longint a, longint b, int sh);
            longint pr;
            pr = a * b + (64'sd1 <<< (sh - 1));
            return sat(pr >>> sh);
        endfunction

        function longint gain(longint n, longint d);
            logic   neg;
            longint nm, dm, q;
            neg = (n < 0) != (d < 0);
            nm = (n < 0 ? -n : n) <<< 16;
            dm = d < 0 ? -d : d;
            q = (2 * nm + dm) / (2 * dm);
            if (q > 64'sd2147483648) q = 64'sd2147483648;
            return sat(neg ? -q : q);
        endfunction

        function void write_reg(kfpv_pkg::t_cfg_idx idx, logic [31:0] d);
            case (idx)
                kfpv_pkg::CFG_QPP: qpp = longint'($signed(d));
                kfpv_pkg::CFG_QPV: qpv = longint'($signed(d));
                kfpv_pkg::CFG_QVP: qvp = longint'($signed(d));
                kfpv_pkg::CFG_QVV: qvv = longint'($signed(d));
                kfpv_pkg::CFG_R:   rn = longint'(d[30:0]);
                kfpv_pkg::CFG_A:   acc = longint'($signed(d));
                default: ;
            endcase
        endfunction

        function void note_input(logic signed [31:0] noise, logic [30:0] dts);
            longint dt, s, z, b0, xr0, xr1, m00, m01, r00, r01, r10, r11, sv, k0, k1, y;
            t_pos   e;
            dt = longint'(dts);
            t = t + dt;
            if (t > 64'sd2147483647) t = 64'sd2147483647;
            s = mulr(mulr(acc, t, 16), t, 17);
            z = sat(s + longint'(noise));
            b0 = mulr(dt, dt, 17);
            xr0 = sat(x0 + mulr(dt, x1, 16) + mulr(b0, acc, 16));
            xr1 = sat(x1 + mulr(dt, acc, 16));
            m00 = sat(p[0] + mulr(dt, p[2], 16));
            m01 = sat(p[1] + mulr(dt, p[3], 16));
            r00 = sat(m00 + mulr(m01, dt, 16) + qpp);
            r01 = sat(m01 + qpv);
            r10 = sat(p[2] + mulr(p[3], dt, 16) + qvp);
            r11 = sat(p[3] + qvv);
            sv = r00 + rn;
            if (sv == 0) begin
                k0 = 0; k1 = 0;
            end else begin
                k0 = gain(r00, sv); k1 = gain(r10, sv);
            end
            y = sat(z - xr0);
            x0 = sat(xr0 + mulr(k0, y, 16));
            x1 = sat(xr1 + mulr(k1, y, 16));
            p[0] = sat(r00 - mulr(k0, r00, 16));
            p[1] = sat(r01 - mulr(k0, r01, 16));
            p[2] = sat(r10 - mulr(k1, r00, 16));
            p[3] = sat(r11 - mulr(k1, r01, 16));
            e.meas = z[31:0]; e.truth = s[31:0]; e.filt = x0[31:0];
            pending.push_back(e);
        endfunction

        function void check_result(t_pos got);
            t_pos e;
            if (pending.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result %p", got);
                return;
            end
            e = pending.pop_front();
            if (got !== e) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch: expected meas %0d true %0d filt %0d, got %0d %0d %0d",
                             e.meas, e.truth, e.filt, got.meas, got.truth, got.filt);
            end
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;
    kfpv_in_if  in_ch (i_clk);
    kfpv_out_if out_ch (i_clk);
    kfpv_cfg_if cfg_ch (i_clk);

    kalman_filter_position_velocity u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .in_ch   (in_ch.sink),
        .out_ch  (out_ch.source),
        .cfg_ch  (cfg_ch.sink)
    );

    track_scoreboard tracker;
    int  send_idle_pct;
    int  recv_idle_pct;
    bit  recv_hold;
    int  idle_cycles;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        in_ch.valid = 1'b0;
        in_ch.noise_sample = '0;
        in_ch.time_step = '0;
        out_ch.ready = 1'b0;
        cfg_ch.valid = 1'b0;
        cfg_ch.index = '0;
        cfg_ch.data = '0;
        i_rst_n = 1'b0;
    end

    // receiver ready, random stalls and one long hold-off
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
        end else begin
            out_ch.ready <= !recv_hold && ($urandom_range(99) >= recv_idle_pct);
            if (out_ch.valid && out_ch.ready)
                tracker.check_result('{out_ch.measured_position, out_ch.true_position,
                                       out_ch.filtered_position});
        end
    end

    // watchdog on cycles with no beat on any channel
    always @(posedge i_clk) begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
            (cfg_ch.valid && cfg_ch.ready) || !i_rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= 20000) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    task automatic send_item(logic signed [31:0] noise, logic [30:0] dts);
        while ($urandom_range(99) < send_idle_pct) @(posedge i_clk);
        in_ch.valid <= 1'b1;
        in_ch.noise_sample <= noise;
        in_ch.time_step <= dts;
        do @(posedge i_clk); while (!in_ch.ready);
        tracker.note_input(noise, dts);
        in_ch.valid <= 1'b0;
        // the block is busy after a beat, so this cycle costs nothing
        @(posedge i_clk);
    endtask

    task automatic write_cfg(kfpv_pkg::t_cfg_idx idx, logic [31:0] d);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data <= d;
        do @(posedge i_clk); while (!cfg_ch.ready);
        tracker.write_reg(idx, d);
        cfg_ch.valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic drain();
        while (tracker.pending.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    task automatic random_items(int n, int big_pct);
        logic [30:0] dts;
        repeat (n) begin
            // mostly small steps keep the filter in a useful range
            if ($urandom_range(99) < big_pct) dts = 31'($urandom);
            else dts = 31'($urandom_range(131072));
            send_item($urandom, dts);
        end
    endtask

    task automatic set_config(logic [31:0] qpp, logic [31:0] qpv, logic [31:0] qvp,
                              logic [31:0] qvv, logic [31:0] rn, logic [31:0] acc);
        drain();
        write_cfg(kfpv_pkg::CFG_QPP, qpp);
        write_cfg(kfpv_pkg::CFG_QPV, qpv);
        write_cfg(kfpv_pkg::CFG_QVP, qvp);
        write_cfg(kfpv_pkg::CFG_QVV, qvv);
        write_cfg(kfpv_pkg::CFG_R, rn);
        write_cfg(kfpv_pkg::CFG_A, acc);
    endtask

    initial begin
        tracker = new();
        tracker.clear();
        send_idle_pct = 36;
        recv_idle_pct = 49;
        recv_hold = 1'b0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // zero innovation variance: zero covariance, zero noise terms
        set_config(32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h10000);
        send_item(32'sh0, 31'h0);
        send_item(32'sh10000, 31'h8000);

        // directed: field extremes on default registers
        set_config(32'd655, 32'd0, 32'd0, 32'd655, 32'd65536000, 32'd32768);
        send_item(32'sh0, 31'h0);
        send_item(32'sh7fffffff, 31'h10000);
        send_item(32'sh80000000, 31'h10000);
        send_item(32'shffffffff, 31'h1);
        send_item(32'sh12345678, 31'h7fffffff);
        send_item(32'sh0, 31'h7fffffff);   // elapsed time pinned at max
        send_item(-32'sh10000, 31'h55555555);

        set_config(32'h80000000, 32'h7fffffff, 32'h80000000, 32'h7fffffff,
                   32'h7fffffff, 32'h80000000);
        send_item(32'sh7fffffff, 31'h2aaaaaaa);
        send_item(32'sh0, 31'h10000);
        // negative variance, unknown index writes ignored
        set_config(32'hfff00000, 32'h0, 32'h0, 32'h100, 32'h1, 32'h7fffffff);
        write_cfg(kfpv_pkg::t_cfg_idx'(3'd6), 32'hdeadbeef);
        write_cfg(kfpv_pkg::t_cfg_idx'(3'd7), 32'h12345678);
        send_item(32'sh100, 31'h10000);
        send_item(-32'sh100, 31'h20000);

        set_config(32'd655, 32'd0, 32'd0, 32'd655, 32'd65536000, 32'd32768);
        random_items(200, 5);

        // long receiver hold-off: the block fills and stalls its input
        recv_hold = 1'b1;
        fork
            random_items(3, 0);
            begin
                repeat (1500) @(posedge i_clk);
                recv_hold = 1'b0;
            end
        join

        send_idle_pct = 49;
        recv_idle_pct = 36;
        set_config($urandom_range(65536), $urandom, $urandom, $urandom_range(65536),
                   $urandom_range(32'h7fffffff, 1), $urandom);
        random_items(200, 10);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        set_config(32'd6554, 32'd100, 32'hffffff00, 32'd6554, 32'd65536, 32'hfffe0000);
        random_items(290, 5);

        drain();
        if (tracker.mismatches == 0 && tracker.pending.size() == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end
endmodule

>>> files.f
+incdir+hw/rtl
hw/rtl/kfpv_pkg.sv
hw/rtl/kfpv_if.sv
hw/rtl/kfpv_div.sv
hw/rtl/kfpv_core.sv
hw/rtl/kalman_filter_position_velocity.sv
hw/rtl/kfpv_checker.sv
test/kfpv_tb_if.sv
test/kalman_filter_position_velocity_tb.sv
